### hw/rtl/lifa_pkg.sv
// Shared types and constants of the LIF neuron array update block.
// Used by lifa_cfg, lifa_pipe and lif_neuron_array_update; depends on nothing.
package lifa_pkg;

  // Fixed field widths of the transaction payloads and the register port.
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned IndexW    = 10;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned SpikeW    = 15;
  localparam int unsigned FracW     = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    RegThreshold     = 3'd0,
    RegResetLevel    = 3'd1,
    RegReciprocalTau = 3'd2,
    RegSoftReset     = 3'd3,
    RegDecayInput    = 3'd4,
    RegInputFrac     = 3'd5,
    RegPotentialFrac = 3'd6,
    RegOutputFrac    = 3'd7
  } cfg_reg_e;

  // Operation codes of an input transaction.
  localparam logic OpUpdate = 1'b0;
  localparam logic OpClear  = 1'b1;

  // Register reset values.
  localparam logic signed [ValueW-1:0] ThresholdRst     = 16'sd16384;
  localparam logic signed [ValueW-1:0] ResetLevelRst    = 16'sd0;
  localparam logic signed [ValueW-1:0] ReciprocalTauRst = 16'sd8192;
  localparam logic                     SoftResetRst     = 1'b1;
  localparam logic                     DecayInputRst    = 1'b1;
  localparam logic [FracW-1:0]         FracBitsRst      = 4'd8;

  // Register contents plus the alignment shifts derived from them.
  typedef struct packed {
    logic signed [ValueW-1:0] threshold;
    logic signed [ValueW-1:0] reset_level;
    logic signed [ValueW-1:0] recip_tau;
    logic                     thr_subtract;
    logic                     input_leak;
    logic [FracW-1:0]         input_frac_bits;
    logic [FracW-1:0]         potential_frac_bits;
    logic [FracW-1:0]         output_frac_bits;
    logic [FracW-1:0]         work_frac;
    logic [FracW-1:0]         shift_v;
    logic [FracW-1:0]         shift_x;
  } cfg_t;

  // Pipeline status seen by the input handshake.
  typedef struct packed {
    logic advance;
    logic hazard;
  } pipe_ctrl_t;

endpackage

### hw/rtl/lifa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; a read at the address being written returns the old data.
module lifa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lifa_cfg.sv
// Configuration register file of the LIF neuron array update block.
// Depends on lifa_pkg for the register indexes, reset values and cfg_t.
module lifa_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lifa_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [lifa_pkg::CfgDataW-1:0]      cfg_data_i,
  output lifa_pkg::cfg_t                     cfg_o
);

  logic signed [lifa_pkg::ValueW-1:0] threshold_q, reset_level_q, rtau_q;
  logic                               thr_sub_q, in_leak_q;
  logic [lifa_pkg::FracW-1:0]         xf_q, pf_q, of_q;
  logic [lifa_pkg::FracW-1:0]         work_frac;

  // Register writes; every index of the port maps to a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= lifa_pkg::ThresholdRst;
      reset_level_q <= lifa_pkg::ResetLevelRst;
      rtau_q        <= lifa_pkg::ReciprocalTauRst;
      thr_sub_q     <= lifa_pkg::SoftResetRst;
      in_leak_q     <= lifa_pkg::DecayInputRst;
      xf_q          <= lifa_pkg::FracBitsRst;
      pf_q          <= lifa_pkg::FracBitsRst;
      of_q          <= lifa_pkg::FracBitsRst;
    end else if (cfg_we_i) begin
      case (lifa_pkg::cfg_reg_e'(cfg_index_i))
        lifa_pkg::RegThreshold:     threshold_q   <= $signed(cfg_data_i);
        lifa_pkg::RegResetLevel:    reset_level_q <= $signed(cfg_data_i);
        lifa_pkg::RegReciprocalTau: rtau_q        <= $signed(cfg_data_i);
        lifa_pkg::RegSoftReset:     thr_sub_q     <= cfg_data_i[0];
        lifa_pkg::RegDecayInput:    in_leak_q     <= cfg_data_i[0];
        lifa_pkg::RegInputFrac:     xf_q          <= cfg_data_i[lifa_pkg::FracW-1:0];
        lifa_pkg::RegPotentialFrac: pf_q          <= cfg_data_i[lifa_pkg::FracW-1:0];
        lifa_pkg::RegOutputFrac:    of_q          <= cfg_data_i[lifa_pkg::FracW-1:0];
        default: ;
      endcase
    end
  end

  // The working format takes the larger of the two fraction widths.
  assign work_frac = (pf_q > xf_q) ? pf_q : xf_q;

  assign cfg_o.threshold           = threshold_q;
  assign cfg_o.reset_level         = reset_level_q;
  assign cfg_o.recip_tau           = rtau_q;
  assign cfg_o.thr_subtract        = thr_sub_q;
  assign cfg_o.input_leak          = in_leak_q;
  assign cfg_o.input_frac_bits     = xf_q;
  assign cfg_o.potential_frac_bits = pf_q;
  assign cfg_o.output_frac_bits    = of_q;
  assign cfg_o.work_frac           = work_frac;
  assign cfg_o.shift_v             = work_frac - pf_q;
  assign cfg_o.shift_x             = work_frac - xf_q;

endmodule

### hw/rtl/lifa_pipe.sv
// Update pipeline: aligns, leaks, fires, saturates and writes a potential back.
// Depends on lifa_pkg; the potential RAM and its read port sit in the top level.
module lifa_pipe #(
  parameter int unsigned Neurons   = 1024,
  parameter int unsigned DataWidth = 16,
  localparam int unsigned AddrW = (Neurons > 1) ? $clog2(Neurons) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lifa_pkg::cfg_t                       cfg_i,
  input  logic                                 accept_i,
  input  logic                                 in_op_i,
  input  logic [lifa_pkg::IndexW-1:0]          in_index_i,
  input  logic signed [lifa_pkg::ValueW-1:0]   in_value_i,
  input  logic [DataWidth-1:0]                 rd_data_i,
  output logic                                 wr_en_o,
  output logic [AddrW-1:0]                     wr_addr_o,
  output logic [DataWidth-1:0]                 wr_data_o,
  output lifa_pkg::pipe_ctrl_t                 ctrl_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lifa_pkg::IndexW-1:0]          out_index_o,
  output logic                                 fired_o,
  output logic [lifa_pkg::SpikeW-1:0]          spike_value_o,
  output logic signed [lifa_pkg::ValueW-1:0]   new_potential_o
);

  // Scaled operands, leak difference, product and working sum widths.
  localparam int unsigned SW  = (DataWidth + 15 > 31) ? DataWidth + 15 : 31;
  localparam int unsigned DDW = SW + 2;
  localparam int unsigned PW  = DDW + lifa_pkg::ValueW;
  localparam int unsigned UW  = PW + 2;
  localparam int unsigned GW  = UW - DataWidth + 1;

  // Saturate a working value to the stored potential range.
  function automatic logic signed [UW-1:0] sat_dw(input logic signed [UW-1:0] val);
    logic signed [UW-1:0] res;
    if (val[UW-1:DataWidth-1] == {GW{val[UW-1]}}) begin
      res = val;
    end else if (val[UW-1]) begin
      res = {{GW{1'b1}}, {(DataWidth-1){1'b0}}};
    end else begin
      res = {{GW{1'b0}}, {(DataWidth-1){1'b1}}};
    end
    return res;
  endfunction

  logic advance;

  // Stage A: waits for the RAM read data.
  logic                              a_vld_q, a_op_q;
  logic [lifa_pkg::IndexW-1:0]       a_idx_q;
  logic signed [lifa_pkg::ValueW-1:0] a_value_q;

  // Stage B: aligned operands and leak difference.
  logic                    b_vld_q, b_op_q;
  logic [lifa_pkg::IndexW-1:0] b_idx_q;
  logic signed [DDW-1:0]   b_diff_q;
  logic signed [SW-1:0]    b_vs_q, b_xs_q, b_ths_q;

  // Stage C: leak product.
  logic                    c_vld_q, c_op_q;
  logic [lifa_pkg::IndexW-1:0] c_idx_q;
  logic signed [PW-1:0]    c_prod_q;
  logic signed [SW-1:0]    c_vs_q, c_xs_q, c_ths_q;

  // Stage D: integrated potential and threshold decision.
  logic                    d_vld_q, d_op_q, d_fire_q;
  logic [lifa_pkg::IndexW-1:0] d_idx_q;
  logic signed [UW-1:0]    d_u_q;
  logic signed [SW-1:0]    d_ths_q;

  // Output register.
  logic                               out_vld_q, out_fire_q;
  logic [lifa_pkg::IndexW-1:0]        out_idx_q;
  logic [lifa_pkg::SpikeW-1:0]        out_spike_q;
  logic signed [lifa_pkg::ValueW-1:0] out_pot_q;

  logic signed [DataWidth-1:0] v;
  logic signed [SW-1:0]        vs_d, xs_d, ths_d, rs_d;
  logic signed [DDW-1:0]       vr_d, diff_d;
  logic signed [PW-1:0]        prod_d, leak_c;
  logic signed [UW-1:0]        u_d, diff_u, sel_u, shifted_u, pre_sat, stored;
  logic                        fire_d;
  logic [lifa_pkg::SpikeW-1:0] spike_d;

  // The whole pipeline moves together whenever the output register can take data.
  assign advance = !out_vld_q || !out_stall_i;

  // An index still in flight has not been written back, so a new read would be stale.
  assign ctrl_o.advance = advance;
  assign ctrl_o.hazard  = (a_vld_q && (a_idx_q == in_index_i)) ||
                          (b_vld_q && (b_idx_q == in_index_i)) ||
                          (c_vld_q && (c_idx_q == in_index_i)) ||
                          (d_vld_q && (d_idx_q == in_index_i));

  // Stage A logic: align potential, input, threshold and reference level, and form the leak difference.
  always_comb begin
    v      = $signed(rd_data_i);
    vs_d   = SW'(v) <<< cfg_i.shift_v;
    xs_d   = SW'(a_value_q) <<< cfg_i.shift_x;
    ths_d  = SW'(cfg_i.threshold) <<< cfg_i.shift_v;
    rs_d   = cfg_i.thr_subtract ? '0 : (SW'(cfg_i.reset_level) <<< cfg_i.shift_v);
    vr_d   = DDW'(vs_d) - DDW'(rs_d);
    diff_d = cfg_i.input_leak ? (DDW'(xs_d) - vr_d) : vr_d;
  end

  // Stage B logic: scale the leak difference by the reciprocal time constant.
  assign prod_d = $signed(b_diff_q) * $signed(cfg_i.recip_tau);

  // Stage C logic: floor shift to the working format, integrate and test.
  always_comb begin
    leak_c = c_prod_q >>> cfg_i.work_frac;
    if (cfg_i.input_leak) begin
      u_d = UW'(c_vs_q) + UW'(leak_c);
    end else begin
      u_d = UW'(c_vs_q) - UW'(leak_c) + UW'(c_xs_q);
    end
    fire_d = (c_op_q == lifa_pkg::OpUpdate) && (u_d >= UW'(c_ths_q));
  end

  // Stage D logic: zero on a clear, reset on a spike, return to potential format, saturate and form the spike value.
  always_comb begin
    diff_u    = d_u_q - UW'(d_ths_q);
    sel_u     = d_fire_q ? diff_u : d_u_q;
    shifted_u = sel_u >>> cfg_i.shift_v;
    if (d_op_q == lifa_pkg::OpClear) begin
      pre_sat = '0;
    end else if (d_fire_q && !cfg_i.thr_subtract) begin
      pre_sat = UW'(cfg_i.reset_level);
    end else begin
      pre_sat = shifted_u;
    end
    stored = sat_dw(pre_sat);
    if (!d_fire_q) begin
      spike_d = '0;
    end else if (&cfg_i.output_frac_bits) begin
      spike_d = '1;
    end else begin
      spike_d = lifa_pkg::SpikeW'(1) << cfg_i.output_frac_bits;
    end
  end

  // Write-back happens as the item moves into the output register.
  assign wr_en_o   = advance && d_vld_q;
  assign wr_addr_o = AddrW'(d_idx_q);
  assign wr_data_o = stored[DataWidth-1:0];

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      a_vld_q   <= accept_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      out_vld_q <= d_vld_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_op_q      <= in_op_i;
      a_idx_q     <= in_index_i;
      a_value_q   <= in_value_i;
      b_op_q      <= a_op_q;
      b_idx_q     <= a_idx_q;
      b_diff_q    <= diff_d;
      b_vs_q      <= vs_d;
      b_xs_q      <= xs_d;
      b_ths_q     <= ths_d;
      c_op_q      <= b_op_q;
      c_idx_q     <= b_idx_q;
      c_prod_q    <= prod_d;
      c_vs_q      <= b_vs_q;
      c_xs_q      <= b_xs_q;
      c_ths_q     <= b_ths_q;
      d_op_q      <= c_op_q;
      d_idx_q     <= c_idx_q;
      d_u_q       <= u_d;
      d_fire_q    <= fire_d;
      d_ths_q     <= c_ths_q;
      out_idx_q   <= d_idx_q;
      out_fire_q  <= d_fire_q;
      out_spike_q <= spike_d;
      out_pot_q   <= stored[lifa_pkg::ValueW-1:0];
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_index_o     = out_idx_q;
  assign fired_o         = out_fire_q;
  assign spike_value_o   = out_spike_q;
  assign new_potential_o = out_pot_q;

endmodule

### hw/rtl/lif_neuron_array_update.sv
// Leaky integrate-and-fire neuron array: one potential update per transaction.
// An accepted transaction passes stages A, B, C and D and then the output register.
// Throughput: one transaction per cycle unless the output stalls; one whose neuron index
// matches one of up to four in flight waits for that read-modify-write of the potential RAM.
// Reset: registers take their reset values; a clearing pass zeroes the RAM, one entry per
// cycle from the first address to the last, and input stays stalled until it ends.
module lif_neuron_array_update #(
  parameter int unsigned NEURONS    = 1024,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lifa_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [lifa_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               in_op_i,
  input  logic [lifa_pkg::IndexW-1:0]        in_index_i,
  input  logic signed [lifa_pkg::ValueW-1:0] in_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lifa_pkg::IndexW-1:0]        out_index_o,
  output logic                               fired_o,
  output logic [lifa_pkg::SpikeW-1:0]        spike_value_o,
  output logic signed [lifa_pkg::ValueW-1:0] new_potential_o
);

  localparam int unsigned AddrW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  lifa_pkg::cfg_t       cfg;
  lifa_pkg::pipe_ctrl_t ctrl;

  logic                  in_accept, live_accept, in_range;
  logic                  clr_busy_q;
  logic [AddrW-1:0]      clr_addr_q;
  logic                  pipe_we, ram_we;
  logic [AddrW-1:0]      pipe_waddr, ram_waddr;
  logic [DATA_WIDTH-1:0] pipe_wdata, ram_wdata, ram_rdata;

  // Input handshake; items beyond the store are taken and dropped.
  assign in_stall_o  = clr_busy_q || !ctrl.advance || ctrl.hazard;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_range    = (32'(in_index_i) < NEURONS);
  assign live_accept = in_accept && in_range;

  // Clearing pass after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(NEURONS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // The clearing pass owns the write port while the pipeline is empty.
  assign ram_we    = clr_busy_q || pipe_we;
  assign ram_waddr = clr_busy_q ? clr_addr_q : pipe_waddr;
  assign ram_wdata = clr_busy_q ? '0 : pipe_wdata;

  lifa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lifa_ram #(
    .Width (DATA_WIDTH),
    .Depth (NEURONS)
  ) u_potential_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (live_accept),
    .raddr_i (AddrW'(in_index_i)),
    .rdata_o (ram_rdata)
  );

  lifa_pipe #(
    .Neurons   (NEURONS),
    .DataWidth (DATA_WIDTH)
  ) u_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .accept_i        (live_accept),
    .in_op_i         (in_op_i),
    .in_index_i      (in_index_i),
    .in_value_i      (in_value_i),
    .rd_data_i       (ram_rdata),
    .wr_en_o         (pipe_we),
    .wr_addr_o       (pipe_waddr),
    .wr_data_o       (pipe_wdata),
    .ctrl_o          (ctrl),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_index_o     (out_index_o),
    .fired_o         (fired_o),
    .spike_value_o   (spike_value_o),
    .new_potential_o (new_potential_o)
  );

endmodule
